@@ hdl/msch_pkg.sv @@
package msch_pkg;

  localparam int POLYPHONY_DEF = 64;
  localparam int CHANNELS_DEF  = 16;

  localparam int DIVIDEND_W = 48;
  localparam int DIVISOR_W  = 24;

  localparam logic [15:0] MS_PER_MIN  = 16'd60000;
  localparam logic [23:0] PCT_DIVISOR = 24'd100;
  localparam logic [3:0]  DRUM_CH     = 4'd9;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_NOTE  = 2'd1,
    MODE_PAUSE = 2'd2,
    MODE_STOP  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    KIND_NOTE_ON  = 3'd0,
    KIND_NOTE_OFF = 3'd1,
    KIND_PROGRAM  = 3'd2,
    KIND_STATUS   = 3'd3,
    KIND_DROPPED  = 3'd4,
    KIND_NOT_DUE  = 3'd5,
    KIND_NONE     = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    REG_TEMPO  = 3'd0,
    REG_SPEED  = 3'd1,
    REG_TPQ    = 3'd2,
    REG_STATUS = 3'd3,
    REG_DRUM   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [3:0]  ch;
    logic [6:0]  key;
    logic [31:0] endt;
  } note_ent_t;

  typedef struct packed {
    kind_t      kind;
    logic [3:0] ch;
    logic [6:0] key;
    logic [6:0] val;
    logic [6:0] ins;
  } event_t;

  function automatic logic [31:0] sat32(input logic [DIVIDEND_W-1:0] v);
    sat32 = (v[DIVIDEND_W-1:32] != '0) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

endpackage

@@ hdl/msch_div.sv @@
module msch_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [msch_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [msch_pkg::DIVISOR_W-1:0]  divisor,
  output logic                           busy,
  output logic                           done,
  output logic [msch_pkg::DIVIDEND_W-1:0] quotient
);
  import msch_pkg::*;

  localparam int STEPS = DIVIDEND_W / 2;
  localparam int SC_W  = $clog2(STEPS);

  logic [DIVISOR_W:0]   rem, r1, r2, t1, t2;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVIDEND_W-1:0] q1, q2;
  logic [SC_W-1:0]      cnt;

  // two restoring steps per cycle
  always_comb begin
    t1 = {rem[DIVISOR_W-1:0], quotient[DIVIDEND_W-1]};
    if (t1 >= {1'b0, dvs}) begin
      r1 = t1 - {1'b0, dvs};
      q1 = {quotient[DIVIDEND_W-2:0], 1'b1};
    end else begin
      r1 = t1;
      q1 = {quotient[DIVIDEND_W-2:0], 1'b0};
    end
    t2 = {r1[DIVISOR_W-1:0], q1[DIVIDEND_W-1]};
    if (t2 >= {1'b0, dvs}) begin
      r2 = t2 - {1'b0, dvs};
      q2 = {q1[DIVIDEND_W-2:0], 1'b1};
    end else begin
      r2 = t2;
      q2 = {q1[DIVIDEND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= '0;
        rem      <= '0;
        dvs      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= r2;
        quotient <= q2;
        cnt      <= cnt + 1'b1;
        if (cnt == SC_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/midi_note_scheduler.sv @@
// Channel  | Handshake                  | Carries
// item     | item_valid / item_ready    | mode, elapsed_ms, channel, key, velocity,
//          |                            | instrument, start_ticks, duration_ticks
// result   | result_valid / result_ready| kind, out_channel, out_key, out_value,
//          |                            | out_instrument, last
// cfg      | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item at a time. Each tick-to-ms or playback conversion runs through a shared
// two-bit-per-cycle divider. Reset clears the count, program cache and time at once; the
// note table needs no clearing. A stalled result side holds the sequencer at its next
// event; one finished result waits in the output register while the next is prepared.
module midi_note_scheduler #(
  parameter int POLYPHONY = msch_pkg::POLYPHONY_DEF,
  parameter int CHANNELS  = msch_pkg::CHANNELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [1:0]  mode,
  input  logic [15:0] elapsed_ms,
  input  logic [3:0]  channel,
  input  logic [6:0]  key,
  input  logic [6:0]  velocity,
  input  logic [6:0]  instrument,
  input  logic [31:0] start_ticks,
  input  logic [31:0] duration_ticks,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  kind,
  output logic [3:0]  out_channel,
  output logic [6:0]  out_key,
  output logic [6:0]  out_value,
  output logic [6:0]  out_instrument,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import msch_pkg::*;

  localparam int CNT_W = $clog2(POLYPHONY + 1);
  localparam int AW    = (POLYPHONY > 1) ? $clog2(POLYPHONY) : 1;
  localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_DIV   = 16'h0002,
    S_DWAIT = 16'h0004,
    S_CMP   = 16'h0008,
    S_NDUE  = 16'h0010,
    S_PROG  = 16'h0020,
    S_MSCAN = 16'h0040,
    S_MDEC  = 16'h0080,
    S_MON   = 16'h0100,
    S_TRD   = 16'h0200,
    S_TCHK  = 16'h0400,
    S_TRDL  = 16'h0800,
    S_TMOVE = 16'h1000,
    S_RRD   = 16'h2000,
    S_RCHK  = 16'h4000,
    S_FIN   = 16'h8000
  } state_t;

  typedef enum logic [1:0] {
    JOB_START = 2'd0,
    JOB_PLAY  = 2'd1,
    JOB_DUR   = 2'd2
  } job_t;

  state_t state;
  job_t   job;

  // configuration
  logic [7:0]  tempo, speed;
  logic [15:0] tpq;
  logic [3:0]  status_ch;
  logic        drum_exempt;

  // item
  mode_t       mode_r;
  logic [3:0]  ch_r;
  logic [6:0]  key_r, vel_r, ins_r;
  logic [31:0] st_ticks, dur_ticks;

  logic [31:0] wall, now, st_ms, end_ms;
  logic [CNT_W-1:0] count, idx, match, tgt;
  logic        found, rv;

  logic [6:0]  prog [CHANNELS];

  note_ent_t   mem [POLYPHONY];
  note_ent_t   rdata, wr_data;
  logic        rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;

  event_t      pend, push_ev;
  logic        pend_v, push_en, fin_en, out_free;

  logic        div_start, div_busy, div_done;
  logic [DIVIDEND_W-1:0] div_dividend, div_q;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [31:0] q_sat;
  logic [32:0] wall_sum, end_sum;
  logic [CNT_W-1:0] cnt_m1;

  logic ch_cached, need_prog, skip_prog, is_status, expired, idx_lt;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == S_IDLE);
  assign out_free   = !result_valid || result_ready;
  assign q_sat      = sat32(div_q);
  assign cnt_m1     = count - 1'b1;
  assign idx_lt     = idx < count;
  assign wall_sum   = {1'b0, wall} + {17'b0, elapsed_ms};
  assign end_sum    = {1'b0, st_ms} + {1'b0, q_sat};

  assign ch_cached = {1'b0, ch_r} < 5'(CHANNELS);
  assign need_prog = ch_cached && (prog[ch_r[CHW-1:0]] != ins_r);
  assign skip_prog = drum_exempt && (ch_r == DRUM_CH);
  assign is_status = (ch_r == status_ch);
  assign expired   = rdata.endt <= now;

  always_comb begin
    div_divisor = DIVISOR_W'((tempo == 8'd0) ? 8'd1 : tempo) *
                  DIVISOR_W'((tpq == 16'd0) ? 16'd1 : tpq);
    case (job)
      JOB_START: div_dividend = DIVIDEND_W'(st_ticks) * DIVIDEND_W'(MS_PER_MIN);
      JOB_DUR:   div_dividend = DIVIDEND_W'(dur_ticks) * DIVIDEND_W'(MS_PER_MIN);
      JOB_PLAY: begin
        div_dividend = DIVIDEND_W'(wall) * DIVIDEND_W'(speed);
        div_divisor  = PCT_DIVISOR;
      end
      default:   div_dividend = '0;
    endcase
  end

  msch_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // note table
  always_ff @(posedge clk) begin
    if (rd_en) rdata <= mem[rd_addr];
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_comb begin
    push_en   = 1'b0;
    push_ev   = '{kind: KIND_NONE, default: '0};
    fin_en    = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx[AW-1:0];
    wr_en     = 1'b0;
    wr_addr   = idx[AW-1:0];
    wr_data   = rdata;
    div_start = 1'b0;
    case (state)
      S_DIV: div_start = 1'b1;
      S_NDUE: begin
        push_en = out_free;
        push_ev = '{kind: KIND_NOT_DUE, ch: ch_r, key: key_r, val: vel_r, ins: 7'd0};
      end
      S_PROG: begin
        push_en = need_prog && !skip_prog && out_free;
        push_ev = '{kind: KIND_PROGRAM, ch: ch_r, key: 7'd0, val: ins_r, ins: 7'd0};
      end
      S_MSCAN: rd_en = idx_lt;
      S_MDEC: begin
        if (found) begin
          push_en = out_free;
          push_ev = '{kind: KIND_NOTE_OFF, ch: ch_r, key: key_r, val: 7'd0, ins: 7'd0};
        end else if (!is_status && count == CNT_W'(POLYPHONY)) begin
          push_en = out_free;
          push_ev = '{kind: KIND_DROPPED, ch: ch_r, key: key_r, val: vel_r, ins: 7'd0};
        end
      end
      S_MON: begin
        push_en = out_free;
        if (is_status) begin
          push_ev = '{kind: KIND_STATUS, ch: ch_r, key: key_r, val: vel_r, ins: ins_r};
        end else begin
          push_ev = '{kind: KIND_NOTE_ON, ch: ch_r, key: key_r, val: vel_r, ins: 7'd0};
          wr_en   = out_free;
          wr_addr = tgt[AW-1:0];
          wr_data = '{ch: ch_r, key: key_r, endt: end_ms};
        end
      end
      S_TRD: rd_en = idx_lt;
      S_TCHK: begin
        push_en = expired && out_free;
        push_ev = '{kind: KIND_NOTE_OFF, ch: rdata.ch, key: rdata.key, val: 7'd0, ins: 7'd0};
      end
      S_TRDL: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m1[AW-1:0];
      end
      S_TMOVE: wr_en = 1'b1;
      S_RRD: rd_en = idx_lt;
      S_RCHK: begin
        push_en = out_free;
        push_ev = '{kind: KIND_NOTE_OFF, ch: rdata.ch, key: rdata.key, val: 7'd0, ins: 7'd0};
      end
      S_FIN: fin_en = out_free;
      default: ;
    endcase
  end

  // hold one event back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pend_v       <= 1'b0;
    end else begin
      if ((push_en && pend_v) || fin_en) begin
        result_valid   <= 1'b1;
        kind           <= pend_v ? pend.kind : KIND_NONE;
        out_channel    <= pend_v ? pend.ch : 4'd0;
        out_key        <= pend_v ? pend.key : 7'd0;
        out_value      <= pend_v ? pend.val : 7'd0;
        out_instrument <= pend_v ? pend.ins : 7'd0;
        last           <= fin_en;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (push_en) begin
        pend   <= push_ev;
        pend_v <= 1'b1;
      end else if (fin_en) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      job         <= JOB_START;
      count       <= '0;
      wall        <= '0;
      tempo       <= 8'd120;
      speed       <= 8'd100;
      tpq         <= 16'd96;
      status_ch   <= 4'd15;
      drum_exempt <= 1'b1;
      found       <= 1'b0;
      rv          <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) prog[i] <= 7'd0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TEMPO:  tempo       <= cfg_data[7:0];
          REG_SPEED:  speed       <= cfg_data[7:0];
          REG_TPQ:    tpq         <= cfg_data;
          REG_STATUS: status_ch   <= cfg_data[3:0];
          REG_DRUM:   drum_exempt <= cfg_data[0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            mode_r    <= mode_t'(mode);
            ch_r      <= channel;
            key_r     <= key;
            vel_r     <= velocity;
            ins_r     <= instrument;
            st_ticks  <= start_ticks;
            dur_ticks <= duration_ticks;
            idx       <= '0;
            case (mode_t'(mode))
              MODE_TICK: begin
                wall  <= wall_sum[32] ? 32'hFFFF_FFFF : wall_sum[31:0];
                job   <= JOB_PLAY;
                state <= S_DIV;
              end
              MODE_NOTE: begin
                job   <= JOB_START;
                state <= S_DIV;
              end
              MODE_STOP: begin
                wall  <= '0;
                state <= S_RRD;
              end
              default: state <= S_RRD;
            endcase
          end
        end
        S_DIV: state <= S_DWAIT;
        S_DWAIT: begin
          if (div_done) begin
            case (job)
              JOB_START: begin
                st_ms <= q_sat;
                job   <= JOB_PLAY;
                state <= S_DIV;
              end
              JOB_PLAY: begin
                now   <= q_sat;
                state <= S_CMP;
              end
              default: begin
                end_ms <= end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
                state  <= S_PROG;
              end
            endcase
          end
        end
        S_CMP: begin
          if (mode_r == MODE_TICK) state <= S_TRD;
          else if (st_ms > now) state <= S_NDUE;
          else begin
            job   <= JOB_DUR;
            state <= S_DIV;
          end
        end
        S_NDUE: if (out_free) state <= S_FIN;
        S_PROG: begin
          if (!(need_prog && !skip_prog) || out_free) begin
            if (need_prog) prog[ch_r[CHW-1:0]] <= ins_r;
            idx   <= '0;
            found <= 1'b0;
            rv    <= 1'b0;
            state <= S_MSCAN;
          end
        end
        S_MSCAN: begin
          rv <= idx_lt;
          if (idx_lt) idx <= idx + 1'b1;
          // last match in table order wins
          if (rv && rdata.ch == ch_r && rdata.key == key_r) begin
            found <= 1'b1;
            match <= idx - 1'b1;
          end
          if (!idx_lt && !rv) state <= S_MDEC;
        end
        S_MDEC: begin
          if (found) begin
            tgt <= match;
            if (out_free) state <= S_MON;
          end else if (is_status) begin
            state <= S_MON;
          end else if (count != CNT_W'(POLYPHONY)) begin
            tgt   <= count;
            count <= count + 1'b1;
            state <= S_MON;
          end else if (out_free) begin
            state <= S_FIN;
          end
        end
        S_MON: if (out_free) state <= S_FIN;
        S_TRD: state <= idx_lt ? S_TCHK : S_FIN;
        S_TCHK: begin
          if (!expired) begin
            idx   <= idx + 1'b1;
            state <= S_TRD;
          end else if (out_free) begin
            if (idx == cnt_m1) begin
              count <= cnt_m1;
              state <= S_TRD;
            end else begin
              state <= S_TRDL;
            end
          end
        end
        S_TRDL: state <= S_TMOVE;
        S_TMOVE: begin
          // last entry now sits at idx; check it again
          count <= cnt_m1;
          state <= S_TCHK;
        end
        S_RRD: begin
          if (idx_lt) state <= S_RCHK;
          else begin
            count <= '0;
            state <= S_FIN;
          end
        end
        S_RCHK: begin
          if (out_free) begin
            idx   <= idx + 1'b1;
            state <= S_RRD;
          end
        end
        S_FIN: if (out_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(POLYPHONY))
    else $error("sounding count above table size");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    item_ready |-> (!pend_v && !div_busy))
    else $error("item taken while earlier work is pending");

  a_fin_last: assert property (@(posedge clk) disable iff (rst)
    fin_en |=> (result_valid && last))
    else $error("final result not marked last");

  a_move_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_TMOVE) |=> (count == $past(count) - 1'b1))
    else $error("swap removal did not shrink the table");

endmodule

@@ dv/testbench.sv @@
module testbench;
  import msch_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  mode = MODE_TICK;
  logic [15:0] elapsed_ms = '0;
  logic [3:0]  channel = '0;
  logic [6:0]  key = '0;
  logic [6:0]  velocity = '0;
  logic [6:0]  instrument = '0;
  logic [31:0] start_ticks = '0;
  logic [31:0] duration_ticks = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  kind;
  logic [3:0]  out_channel;
  logic [6:0]  out_key;
  logic [6:0]  out_value;
  logic [6:0]  out_instrument;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_TEMPO;
  logic [15:0] cfg_data = '0;

  midi_note_scheduler DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] ms;
    logic [3:0]  ch;
    logic [6:0]  key;
    logic [6:0]  vel;
    logic [6:0]  ins;
    logic [31:0] start;
    logic [31:0] dur;
  } note_item_t;

  typedef struct {
    logic [2:0] kind;
    logic [3:0] ch;
    logic [6:0] key;
    logic [6:0] val;
    logic [6:0] ins;
    logic       last;
  } midi_event_t;

  typedef struct {
    note_item_t  it;
    bit          typed;
    midi_event_t ev;
  } stim_row_t;

  // scheduler shadow state
  logic [3:0]  sh_ch [64];
  logic [6:0]  sh_key [64];
  logic [31:0] sh_end [64];
  int          sh_count;
  logic [6:0]  sh_prog [16];
  logic [31:0] sh_wall;
  logic [7:0]  tempo, speed;
  logic [15:0] tpq;
  logic [3:0]  status_ch;
  logic        drum_exempt;

  midi_event_t pending_events[$];
  int          mismatches = 0;
  int          sender_idle = 0;
  int          receiver_idle = 0;
  int          hold_off = 0;

  function automatic logic [31:0] sat(longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  function automatic logic [31:0] ticks_to_ms(logic [31:0] t);
    longint unsigned d;
    d = longint'(tempo == 0 ? 8'd1 : tempo) * longint'(tpq == 0 ? 16'd1 : tpq);
    return sat(longint'(t) * 60000 / d);
  endfunction

  function automatic logic [31:0] playback_now();
    return sat(longint'(sh_wall) * longint'(speed) / 100);
  endfunction

  function automatic midi_event_t mk(kind_t k, logic [3:0] c, logic [6:0] ky,
                                     logic [6:0] v, logic [6:0] i);
    midi_event_t e;
    e.kind = k; e.ch = c; e.key = ky; e.val = v; e.ins = i; e.last = 1'b0;
    return e;
  endfunction

  // Work out the events one item causes and advance the shadow state.
  function automatic void schedule_note(note_item_t it, ref midi_event_t evs[$]);
    logic [31:0] now, st, fin;
    int i, hit;
    bit is_status;
    evs = {};
    if (it.mode == MODE_TICK) begin
      sh_wall = sat(longint'(sh_wall) + longint'(it.ms));
      now = playback_now();
      i = 0;
      while (i < sh_count) begin
        if (sh_end[i] <= now) begin
          evs.push_back(mk(KIND_NOTE_OFF, sh_ch[i], sh_key[i], 0, 0));
          sh_ch[i] = sh_ch[sh_count-1];
          sh_key[i] = sh_key[sh_count-1];
          sh_end[i] = sh_end[sh_count-1];
          sh_count--;
        end else begin
          i++;
        end
      end
    end else if (it.mode == MODE_NOTE) begin
      st = ticks_to_ms(it.start);
      if (st > playback_now()) begin
        evs.push_back(mk(KIND_NOT_DUE, it.ch, it.key, it.vel, 0));
      end else begin
        fin = sat(longint'(st) + longint'(ticks_to_ms(it.dur)));
        is_status = (it.ch == status_ch);
        hit = 64;
        if (sh_prog[it.ch] != it.ins) begin
          if (!(drum_exempt && it.ch == DRUM_CH))
            evs.push_back(mk(KIND_PROGRAM, it.ch, 0, it.ins, 0));
          sh_prog[it.ch] = it.ins;
        end
        for (i = 0; i < sh_count; i++)
          if (sh_ch[i] == it.ch && sh_key[i] == it.key) hit = i;
        if (hit < 64) begin
          evs.push_back(mk(KIND_NOTE_OFF, it.ch, it.key, 0, 0));
        end else if (!is_status) begin
          if (sh_count < 64) begin
            hit = sh_count;
            sh_count++;
          end else begin
            evs.push_back(mk(KIND_DROPPED, it.ch, it.key, it.vel, 0));
          end
        end
        if (is_status) begin
          evs.push_back(mk(KIND_STATUS, it.ch, it.key, it.vel, it.ins));
        end else if (hit < 64) begin
          evs.push_back(mk(KIND_NOTE_ON, it.ch, it.key, it.vel, 0));
          sh_ch[hit] = it.ch; sh_key[hit] = it.key; sh_end[hit] = fin;
        end
      end
    end else begin
      for (i = 0; i < sh_count; i++)
        evs.push_back(mk(KIND_NOTE_OFF, sh_ch[i], sh_key[i], 0, 0));
      sh_count = 0;
      if (it.mode == MODE_STOP) sh_wall = '0;
    end
    if (evs.size() == 0) evs.push_back(mk(KIND_NONE, 0, 0, 0, 0));
    evs[evs.size()-1].last = 1'b1;
  endfunction

  // Offer one item; called just after a rising edge. Returns at the transfer edge.
  task automatic send_item(note_item_t it, bit typed, midi_event_t typed_ev);
    midi_event_t evs[$];
    if (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle) @(posedge clk);
    end
    item_valid <= 1'b1;
    mode <= it.mode; elapsed_ms <= it.ms; channel <= it.ch; key <= it.key;
    velocity <= it.vel; instrument <= it.ins;
    start_ticks <= it.start; duration_ticks <= it.dur;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    schedule_note(it, evs);
    if (typed) evs = '{typed_ev};
    foreach (evs[i]) pending_events.push_back(evs[i]);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    item_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_TEMPO:  tempo = val[7:0];
      REG_SPEED:  speed = val[7:0];
      REG_TPQ:    tpq = val;
      REG_STATUS: status_ch = val[3:0];
      REG_DRUM:   drum_exempt = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic note_item_t rand_item(bit burst, int n);
    note_item_t it;
    int r;
    r = $urandom_range(99);
    it.mode  = (r < 60) ? MODE_NOTE : (r < 90) ? MODE_TICK : (r < 95) ? MODE_PAUSE : MODE_STOP;
    it.ms    = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 500));
    it.ch    = ($urandom_range(3) == 0) ? ($urandom_range(1) ? status_ch : DRUM_CH)
                                        : 4'($urandom);
    it.key   = ($urandom_range(1)) ? 7'($urandom_range(60, 67)) : 7'($urandom);
    it.vel   = 7'($urandom);
    it.ins   = ($urandom_range(1)) ? 7'($urandom_range(0, 3)) : 7'($urandom);
    r = $urandom_range(9);
    it.start = (r < 5) ? 32'd0 : (r < 9) ? 32'($urandom_range(0, 200)) : 32'($urandom);
    r = $urandom_range(9);
    it.dur   = (r < 2) ? 32'd0 : (r < 9) ? 32'($urandom_range(0, 2000)) : 32'($urandom);
    if (burst) begin
      // fill the table past its size with distinct keys on one channel
      it.mode = MODE_NOTE; it.ch = 4'd3; it.key = 7'(n); it.start = '0;
      it.dur = 32'hFFFF_0000;
    end
    return it;
  endfunction

  // result side: random stall, long hold-off on request, compare every transfer
  always @(posedge clk) begin
    midi_event_t want;
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= !($urandom_range(99) < receiver_idle);
    end
    if (!rst && result_valid && result_ready) begin
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected event kind=%0d ch=%0d key=%0d", kind, out_channel, out_key);
      end else begin
        want = pending_events.pop_front();
        if (kind != want.kind || out_channel != want.ch || out_key != want.key ||
            out_value != want.val || out_instrument != want.ins || last != want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("event mismatch: exp k%0d c%0d n%0d v%0d i%0d l%0d got k%0d c%0d n%0d v%0d i%0d l%0d",
                     want.kind, want.ch, want.key, want.val, want.ins, want.last,
                     kind, out_channel, out_key, out_value, out_instrument, last);
        end
      end
    end
  end

  initial begin
    #(12 * 3_000_000);
    $display("** midi_note_scheduler: FAILED **");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    note_item_t it;
    midi_event_t none_ev;
    int n;
    tempo = 8'd120; speed = 8'd100; tpq = 16'd96; status_ch = 4'd15; drum_exempt = 1'b1;
    sh_count = 0; sh_wall = '0;
    foreach (sh_prog[i]) sh_prog[i] = '0;
    none_ev = mk(KIND_NONE, 0, 0, 0, 0);
    none_ev.last = 1'b1;

    // mode ms ch key vel ins start dur
    rows.push_back('{'{MODE_TICK, 16'd0, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 1, none_ev});
    rows.push_back('{'{MODE_PAUSE, 16'd0, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 1, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd5, 7'd33, 7'd99, 7'd1, 32'hFFFF_FFFF, 32'd5}, 1,
                     '{KIND_NOT_DUE, 4'd5, 7'd33, 7'd99, 7'd0, 1'b1}});
    rows.push_back('{'{MODE_TICK, 16'hFFFF, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd0, 7'd127, 7'd127, 7'd127, 32'd0, 32'hFFFF_FFFF},
                     0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd0, 7'd127, 7'd64, 7'd127, 32'd10, 32'd500}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd9, 7'd36, 7'd80, 7'd5, 32'd0, 32'd100}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd15, 7'd10, 7'd70, 7'd3, 32'd0, 32'd100}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd15, 7'd10, 7'd71, 7'd3, 32'd0, 32'd100}, 0, none_ev});
    rows.push_back('{'{MODE_TICK, 16'd100, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd7, 7'd1, 7'd1, 7'd2, 32'd1000, 32'd1}, 0, none_ev});
    rows.push_back('{'{MODE_STOP, 16'd0, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd2, 7'd64, 7'd90, 7'd2, 32'd96, 32'd1}, 0, none_ev});
    rows.push_back('{'{MODE_TICK, 16'hFFFF, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd2, 7'd64, 7'd90, 7'd2, 32'd96, 32'd1}, 0, none_ev});
    rows.push_back('{'{MODE_NOTE, 16'd0, 4'd9, 7'd36, 7'd80, 7'd6, 32'd0, 32'd100}, 0, none_ev});
    rows.push_back('{'{MODE_PAUSE, 16'd0, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0}, 0, none_ev});

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].ev);

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle   = (phase == 0) ? 15 : (phase == 1) ? 45 : 0;
      receiver_idle = (phase == 0) ? 45 : (phase == 1) ? 15 : 0;
      case (phase)
        0: begin
          write_reg(REG_TEMPO, 16'd255); write_reg(REG_SPEED, 16'd255);
          write_reg(REG_TPQ, 16'hFFFF); write_reg(REG_STATUS, 16'd0);
          write_reg(REG_DRUM, 16'd0);
        end
        1: begin
          write_reg(REG_TEMPO, 16'd1); write_reg(REG_SPEED, 16'd1);
          write_reg(REG_TPQ, 16'd1); write_reg(REG_STATUS, 16'd9);
          write_reg(REG_DRUM, 16'd1);
        end
        default: begin
          // zero divisors count as one
          write_reg(REG_TEMPO, 16'd0); write_reg(REG_SPEED, 16'd100);
          write_reg(REG_TPQ, 16'd0); write_reg(REG_STATUS, 16'd15);
          write_reg(REG_DRUM, 16'd0);
        end
      endcase
      n = 0;
      if (phase == 0) begin
        // stop the result side while the table fills and overflows
        it = '{MODE_STOP, 16'd0, 4'd0, 7'd0, 7'd0, 7'd0, 32'd0, 32'd0};
        send_item(it, 0, none_ev);
        hold_off = 600;
        for (; n < 68; n++) send_item(rand_item(1, n), 0, none_ev);
      end
      for (; n < 35 + 10 * phase; n++) send_item(rand_item(0, n), 0, none_ev);
    end
    item_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("** midi_note_scheduler: PASSED **");
    end else begin
      $display("** midi_note_scheduler: FAILED **");
    end
    $finish;
  end
endmodule
